>>> rtl/lkv_pkg.sv
// shared types and constants for the lru key-value cache
`default_nettype none
package lkv_pkg;

  localparam int KEY_W       = 32;
  localparam int CAP_W       = 5;
  localparam int ENTRIES_DEF = 16;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  localparam logic signed [KEY_W-1:0] MISS_VALUE = -KEY_W'(1);

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic signed [KEY_W-1:0] value;
  } kv_t;

endpackage
`default_nettype wire

>>> rtl/lkv_store.sv
// entry memory: key, value and recency rank per slot, one write and one registered read
`default_nettype none
module lkv_store #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic          clk,
  input  wire logic [IW-1:0] rd_addr,
  output lkv_pkg::kv_t       rd_kv,
  output logic [IW-1:0]      rd_age,
  input  wire logic          wr_en,
  input  wire logic [IW-1:0] wr_addr,
  input  wire lkv_pkg::kv_t  wr_kv,
  input  wire logic [IW-1:0] wr_age
);
  import lkv_pkg::*;

  kv_t         kv_mem  [ENTRIES];
  logic [IW-1:0] age_mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      kv_mem[wr_addr]  <= wr_kv;
      age_mem[wr_addr] <= wr_age;
    end
  end

  always_ff @(posedge clk) begin
    rd_kv  <= kv_mem[rd_addr];
    rd_age <= age_mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> rtl/lkv_engine.sv
// lookup and recency sequencer: scan pass, decision, read-modify-write pass, result register
`default_nettype none
module lkv_engine #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF,
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_wr_en,
  input  wire logic [lkv_pkg::CAP_W-1:0]   cfg_wr_data,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        in_command,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] in_lookup_key,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] in_write_value,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic signed [lkv_pkg::KEY_W-1:0] out_read_value,
  output logic                             out_evicted,
  output logic signed [lkv_pkg::KEY_W-1:0] out_evicted_key,
  output logic [IW-1:0]                    mem_rd_addr,
  input  wire lkv_pkg::kv_t                mem_rd_kv,
  input  wire logic [IW-1:0]               mem_rd_age,
  output logic                             mem_wr_en,
  output logic [IW-1:0]                    mem_wr_addr,
  output lkv_pkg::kv_t                     mem_wr_kv,
  output logic [IW-1:0]                    mem_wr_age
);
  import lkv_pkg::*;

  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_UPDATE,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r, cap_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic [ENTRIES-1:0] valid_r, valid_nxt;

  logic                    cmd_r, cmd_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] wval_r, wval_nxt;

  logic [IW-1:0] idx_r, idx_nxt;
  logic          issue_done_r, issue_done_nxt;
  logic          chk_vld_r, chk_vld_nxt;
  logic [IW-1:0] chk_idx_r, chk_idx_nxt;

  logic                    hit_r, hit_nxt;
  logic [IW-1:0]           hit_idx_r, hit_idx_nxt;
  logic [IW-1:0]           hit_age_r, hit_age_nxt;
  logic signed [KEY_W-1:0] hit_val_r, hit_val_nxt;
  logic                    old_found_r, old_found_nxt;
  logic [IW-1:0]           old_idx_r, old_idx_nxt;
  logic [IW-1:0]           old_age_r, old_age_nxt;
  logic signed [KEY_W-1:0] old_key_r, old_key_nxt;
  logic                    free_found_r, free_found_nxt;
  logic [IW-1:0]           free_idx_r, free_idx_nxt;

  logic          ins_mode_r, ins_mode_nxt;
  logic          evict_r, evict_nxt;
  logic [IW-1:0] ins_idx_r, ins_idx_nxt;

  logic                    res_hit_r, res_hit_nxt;
  logic signed [KEY_W-1:0] res_rd_r, res_rd_nxt;
  logic                    res_ev_r, res_ev_nxt;
  logic signed [KEY_W-1:0] res_evk_r, res_evk_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic                    out_hit_r, out_hit_nxt;
  logic signed [KEY_W-1:0] out_rd_r, out_rd_nxt;
  logic                    out_ev_r, out_ev_nxt;
  logic signed [KEY_W-1:0] out_evk_r, out_evk_nxt;

  logic [CW-1:0] cap_eff;
  logic          cur_vld;

  assign in_stall        = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_rd_r;
  assign out_evicted     = out_ev_r;
  assign out_evicted_key = out_evk_r;

  assign mem_rd_addr = idx_r;
  assign mem_wr_addr = chk_idx_r;
  assign cur_vld     = valid_r[chk_idx_r];

  always_comb begin
    if (int'(cap_r) > ENTRIES) begin
      cap_eff = CW'(ENTRIES);
    end else begin
      cap_eff = CW'(cap_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    cnt_nxt        = cnt_r;
    valid_nxt      = valid_r;
    cmd_nxt        = cmd_r;
    key_nxt        = key_r;
    wval_nxt       = wval_r;
    idx_nxt        = idx_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_age_nxt    = hit_age_r;
    hit_val_nxt    = hit_val_r;
    old_found_nxt  = old_found_r;
    old_idx_nxt    = old_idx_r;
    old_age_nxt    = old_age_r;
    old_key_nxt    = old_key_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    ins_mode_nxt   = ins_mode_r;
    evict_nxt      = evict_r;
    ins_idx_nxt    = ins_idx_r;
    res_hit_nxt    = res_hit_r;
    res_rd_nxt     = res_rd_r;
    res_ev_nxt     = res_ev_r;
    res_evk_nxt    = res_evk_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_hit_nxt    = out_hit_r;
    out_rd_nxt     = out_rd_r;
    out_ev_nxt     = out_ev_r;
    out_evk_nxt    = out_evk_r;
    mem_wr_en      = 1'b0;
    mem_wr_kv      = mem_rd_kv;
    mem_wr_age     = mem_rd_age;

    // one read issued per cycle in both passes, its data checked in the next cycle
    if ((state_r == ST_SCAN || state_r == ST_UPDATE) && !issue_done_r) begin
      chk_vld_nxt = 1'b1;
      chk_idx_nxt = idx_r;
      if (idx_r == LAST_IDX) begin
        issue_done_nxt = 1'b1;
      end else begin
        idx_nxt = idx_r + IW'(1);
      end
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd_nxt        = in_command;
          key_nxt        = in_lookup_key;
          wval_nxt       = in_write_value;
          idx_nxt        = '0;
          issue_done_nxt = 1'b0;
          hit_nxt        = 1'b0;
          old_found_nxt  = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chk_vld_r) begin
          if (cur_vld && mem_rd_kv.key == key_r) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = chk_idx_r;
            hit_age_nxt = mem_rd_age;
            hit_val_nxt = mem_rd_kv.value;
          end
          if (cur_vld && (!old_found_r || mem_rd_age > old_age_r)) begin
            old_found_nxt = 1'b1;
            old_idx_nxt   = chk_idx_r;
            old_age_nxt   = mem_rd_age;
            old_key_nxt   = mem_rd_kv.key;
          end
          if (!cur_vld && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = chk_idx_r;
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        idx_nxt        = '0;
        issue_done_nxt = 1'b0;
        res_hit_nxt    = hit_r;
        res_rd_nxt     = '0;
        res_ev_nxt     = 1'b0;
        res_evk_nxt    = '0;
        ins_mode_nxt   = 1'b0;
        evict_nxt      = 1'b0;
        state_nxt      = ST_RESULT;
        if (hit_r) begin
          if (cmd_r == CMD_GET) begin
            res_rd_nxt = hit_val_r;
          end
          state_nxt = ST_UPDATE;
        end else if (cmd_r == CMD_GET) begin
          res_rd_nxt = MISS_VALUE;
        end else if (cap_eff == '0) begin
          // nothing kept: the new item is dropped at once
          res_ev_nxt  = 1'b1;
          res_evk_nxt = key_r;
        end else begin
          ins_mode_nxt = 1'b1;
          state_nxt    = ST_UPDATE;
          if (cnt_r >= cap_eff) begin
            evict_nxt   = 1'b1;
            res_ev_nxt  = 1'b1;
            res_evk_nxt = old_key_r;
            if (!free_found_r || old_idx_r < free_idx_r) begin
              ins_idx_nxt = old_idx_r;
            end else begin
              ins_idx_nxt = free_idx_r;
            end
          end else begin
            ins_idx_nxt = free_idx_r;
            cnt_nxt     = cnt_r + CW'(1);
          end
        end
      end
      ST_UPDATE: begin
        if (chk_vld_r) begin
          if (!ins_mode_r) begin
            if (chk_idx_r == hit_idx_r) begin
              mem_wr_en  = 1'b1;
              mem_wr_age = '0;
              if (cmd_r == CMD_PUT) begin
                mem_wr_kv.value = wval_r;
              end
            end else if (cur_vld && mem_rd_age < hit_age_r) begin
              mem_wr_en  = 1'b1;
              mem_wr_age = mem_rd_age + IW'(1);
            end
          end else begin
            if (chk_idx_r == ins_idx_r) begin
              mem_wr_en       = 1'b1;
              mem_wr_kv.key   = key_r;
              mem_wr_kv.value = wval_r;
              mem_wr_age      = '0;
              valid_nxt[chk_idx_r] = 1'b1;
            end else if (evict_r && chk_idx_r == old_idx_r) begin
              valid_nxt[chk_idx_r] = 1'b0;
            end else if (cur_vld) begin
              mem_wr_en  = 1'b1;
              mem_wr_age = mem_rd_age + IW'(1);
            end
          end
          if (chk_idx_r == LAST_IDX) begin
            state_nxt = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = res_hit_r;
          out_rd_nxt    = res_rd_r;
          out_ev_nxt    = res_ev_r;
          out_evk_nxt   = res_evk_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // capacity write empties the store
    if (cfg_wr_en) begin
      cap_nxt   = cfg_wr_data;
      valid_nxt = '0;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cap_r        <= CAP_RESET;
      cnt_r        <= '0;
      valid_r      <= '0;
      issue_done_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cap_r        <= cap_nxt;
      cnt_r        <= cnt_nxt;
      valid_r      <= valid_nxt;
      issue_done_r <= issue_done_nxt;
      chk_vld_r    <= chk_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    cmd_r        <= cmd_nxt;
    key_r        <= key_nxt;
    wval_r       <= wval_nxt;
    idx_r        <= idx_nxt;
    chk_idx_r    <= chk_idx_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_age_r    <= hit_age_nxt;
    hit_val_r    <= hit_val_nxt;
    old_found_r  <= old_found_nxt;
    old_idx_r    <= old_idx_nxt;
    old_age_r    <= old_age_nxt;
    old_key_r    <= old_key_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    ins_mode_r   <= ins_mode_nxt;
    evict_r      <= evict_nxt;
    ins_idx_r    <= ins_idx_nxt;
    res_hit_r    <= res_hit_nxt;
    res_rd_r     <= res_rd_nxt;
    res_ev_r     <= res_ev_nxt;
    res_evk_r    <= res_evk_nxt;
    out_hit_r    <= out_hit_nxt;
    out_rd_r     <= out_rd_nxt;
    out_ev_r     <= out_ev_nxt;
    out_evk_r    <= out_evk_nxt;
  end

endmodule
`default_nettype wire

>>> rtl/lru_key_value_cache.sv
// top level of the lru key-value cache: sequencer plus entry memory
//
//   channel  direction  handshake              payload
//   in       input      in_valid / in_stall    in_command, in_lookup_key, in_write_value
//   out      output     out_valid / out_stall  out_hit, out_read_value, out_evicted,
//                                              out_evicted_key
//   cfg      input      cfg_wr_en              cfg_wr_data (capacity)
//
// an item makes a read-modify-write pass after its scan pass when entries change (hits
// and inserting puts) and goes from the decision straight to the result otherwise
// one memory read port serves both passes: one scan pass and one read-modify-write pass,
// one slot per cycle each
// synchronous reset empties the store and sets capacity to 16; a capacity write also
// empties it
// a finished result waits in the output register while the next item is worked on
`default_nettype none
module lru_key_value_cache #(
  parameter int ENTRIES = lkv_pkg::ENTRIES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [lkv_pkg::CAP_W-1:0]        cfg_wr_data,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic                             in_command,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] in_lookup_key,
  input  wire logic signed [lkv_pkg::KEY_W-1:0] in_write_value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic                                  out_hit,
  output logic signed [lkv_pkg::KEY_W-1:0]      out_read_value,
  output logic                                  out_evicted,
  output logic signed [lkv_pkg::KEY_W-1:0]      out_evicted_key
);
  import lkv_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic [IW-1:0] mem_rd_addr;
  kv_t           mem_rd_kv;
  logic [IW-1:0] mem_rd_age;
  logic          mem_wr_en;
  logic [IW-1:0] mem_wr_addr;
  kv_t           mem_wr_kv;
  logic [IW-1:0] mem_wr_age;

  lkv_engine #(
    .ENTRIES(ENTRIES)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_command      (in_command),
    .in_lookup_key   (in_lookup_key),
    .in_write_value  (in_write_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_hit         (out_hit),
    .out_read_value  (out_read_value),
    .out_evicted     (out_evicted),
    .out_evicted_key (out_evicted_key),
    .mem_rd_addr     (mem_rd_addr),
    .mem_rd_kv       (mem_rd_kv),
    .mem_rd_age      (mem_rd_age),
    .mem_wr_en       (mem_wr_en),
    .mem_wr_addr     (mem_wr_addr),
    .mem_wr_kv       (mem_wr_kv),
    .mem_wr_age      (mem_wr_age)
  );

  lkv_store #(
    .ENTRIES(ENTRIES)
  ) u_store (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .rd_kv   (mem_rd_kv),
    .rd_age  (mem_rd_age),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_kv   (mem_wr_kv),
    .wr_age  (mem_wr_age)
  );

endmodule
`default_nettype wire

>>> verif/tb_top.sv
// testbench for the lru key-value cache: directed and random get/put traffic checked per item
`timescale 1ns / 1ps
module tb_top;
  import lkv_pkg::*;

  localparam int ENTRIES        = ENTRIES_DEF;
  localparam int SETTLE_CYCLES  = 2*ENTRIES + 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 190;

  typedef struct packed {
    logic                    hit;
    logic signed [KEY_W-1:0] read_value;
    logic                    evicted;
    logic signed [KEY_W-1:0] evicted_key;
  } cache_reply_t;

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    cfg_wr_en      = 1'b0;
  logic [CAP_W-1:0]        cfg_wr_data    = '0;
  logic                    in_valid       = 1'b0;
  logic                    in_stall;
  logic                    in_command     = CMD_GET;
  logic signed [KEY_W-1:0] in_lookup_key  = '0;
  logic signed [KEY_W-1:0] in_write_value = '0;
  logic                    out_valid;
  logic                    out_stall      = 1'b0;
  logic                    out_hit;
  logic signed [KEY_W-1:0] out_read_value;
  logic                    out_evicted;
  logic signed [KEY_W-1:0] out_evicted_key;

  // shadow copy of the store
  int                      shadow_capacity;
  bit                      shadow_valid [ENTRIES];
  logic signed [KEY_W-1:0] shadow_key   [ENTRIES];
  logic signed [KEY_W-1:0] shadow_value [ENTRIES];
  int                      shadow_age   [ENTRIES];
  int                      shadow_count;

  cache_reply_t            pending_replies[$];
  int                      err_count     = 0;
  int                      idle_cycles   = 0;
  bit                      steady_flow   = 1'b0;
  int                      hold_len      = 0;
  int                      hold_req_cnt  = 0;
  logic signed [KEY_W-1:0] key_pool [32];
  int                      pool_size;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_command     (in_command),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key)
  );

  always #10 clk = ~clk;

  function automatic void clear_shadow();
    int i;
    for (i = 0; i < ENTRIES; i++) begin
      shadow_valid[i] = 1'b0;
      shadow_age[i]   = 0;
    end
    shadow_count = 0;
  endfunction

  // move slot to the front of the recency order
  function automatic void promote_slot(input int slot);
    int i;
    int rank;
    rank = shadow_age[slot];
    for (i = 0; i < ENTRIES; i++)
      if (shadow_valid[i] && shadow_age[i] < rank) shadow_age[i]++;
    shadow_age[slot] = 0;
  endfunction

  function automatic cache_reply_t lru_access(input logic cmd,
                                              input logic signed [KEY_W-1:0] key,
                                              input logic signed [KEY_W-1:0] value);
    cache_reply_t r;
    int i;
    int slot;
    int cap;
    int oldest;
    r = '0;
    slot = -1;
    for (i = 0; i < ENTRIES; i++)
      if (slot < 0 && shadow_valid[i] && shadow_key[i] == key) slot = i;
    if (cmd == CMD_GET) begin
      if (slot >= 0) begin
        r.hit = 1'b1;
        r.read_value = shadow_value[slot];
        promote_slot(slot);
      end else begin
        r.read_value = MISS_VALUE;
      end
    end else if (slot >= 0) begin
      r.hit = 1'b1;
      shadow_value[slot] = value;
      promote_slot(slot);
    end else begin
      cap = (shadow_capacity > ENTRIES) ? ENTRIES : shadow_capacity;
      if (cap == 0) begin
        // nothing can be kept: the new key goes straight back out
        r.evicted = 1'b1;
        r.evicted_key = key;
      end else begin
        if (shadow_count >= cap) begin
          oldest = -1;
          for (i = 0; i < ENTRIES; i++)
            if (shadow_valid[i] && (oldest < 0 || shadow_age[i] > shadow_age[oldest]))
              oldest = i;
          if (oldest >= 0) begin
            r.evicted = 1'b1;
            r.evicted_key = shadow_key[oldest];
            shadow_valid[oldest] = 1'b0;
            shadow_count--;
          end
        end
        for (i = 0; i < ENTRIES; i++)
          if (shadow_valid[i]) shadow_age[i]++;
        slot = -1;
        for (i = 0; i < ENTRIES; i++)
          if (slot < 0 && !shadow_valid[i]) slot = i;
        shadow_valid[slot] = 1'b1;
        shadow_key[slot]   = key;
        shadow_value[slot] = value;
        shadow_age[slot]   = 0;
        shadow_count++;
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string what, input logic [KEY_W-1:0] want,
                               input logic [KEY_W-1:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    end
  endtask

  // result side: check each accepted item, then pick the stall for the next cycle
  always @(posedge clk) begin : reply_check
    cache_reply_t want;
    int hold_taken;
    int hold_left;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        err_count++;
        $display("%0t: unexpected result, expected none, actual hit=%b rd=%h ev=%b key=%h",
                 $time, out_hit, out_read_value, out_evicted, out_evicted_key);
      end else begin
        want = pending_replies.pop_front();
        compare_field("hit", KEY_W'(want.hit), KEY_W'(out_hit));
        compare_field("read_value", want.read_value, out_read_value);
        compare_field("evicted", KEY_W'(want.evicted), KEY_W'(out_evicted));
        compare_field("evicted_key", want.evicted_key, out_evicted_key);
      end
    end
    if (hold_req_cnt != hold_taken) begin
      hold_taken = hold_req_cnt;
      hold_left  = hold_len;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady_flow && ($urandom_range(99) < 12);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // offer one item, possibly after a random gap, and return at the edge that takes it
  task automatic send_op(input logic cmd, input logic signed [KEY_W-1:0] key,
                         input logic signed [KEY_W-1:0] value);
    if (!steady_flow && $urandom_range(99) < 12) begin
      in_valid       <= 1'b0;
      in_command     <= 1'($urandom_range(1));
      in_lookup_key  <= $urandom;
      in_write_value <= $urandom;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= cmd;
    in_lookup_key  <= key;
    in_write_value <= value;
    do @(posedge clk); while (in_stall);
    pending_replies.push_back(lru_access(cmd, key, value));
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_capacity(input int cap);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= CAP_W'(cap);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_capacity = cap;
    clear_shadow();
  endtask

  task automatic test_directed_ops();
    send_op(CMD_GET, 0, 0);
    send_op(CMD_PUT, 32'sh7FFFFFFF, 32'sh80000000);
    send_op(CMD_PUT, 32'sh80000000, 32'sh7FFFFFFF);
    send_op(CMD_PUT, 0, -1);
    send_op(CMD_PUT, -1, 0);
    send_op(CMD_GET, 32'sh7FFFFFFF, 0);
    send_op(CMD_GET, 32'sh80000000, 0);
    send_op(CMD_GET, -1, 32'sh5A5A5A5A);
    send_op(CMD_PUT, 0, 12345);
    send_op(CMD_GET, 0, 0);
    send_op(CMD_GET, 1, -1);
  endtask

  task automatic test_capacity_limits();
    set_capacity(0);
    send_op(CMD_PUT, 5, 7);
    send_op(CMD_GET, 5, 0);
    set_capacity(1);
    send_op(CMD_PUT, 10, 1);
    send_op(CMD_PUT, 11, 2);
    send_op(CMD_GET, 10, 0);
    send_op(CMD_GET, 11, 0);
    set_capacity(2);
    send_op(CMD_PUT, 20, 3);
    send_op(CMD_PUT, 21, 4);
    send_op(CMD_GET, 20, 0);
    send_op(CMD_PUT, 22, 5);
    send_op(CMD_GET, 21, 0);
    send_op(CMD_GET, 22, 0);
  endtask

  task automatic fill_key_pool(input int cap);
    int i;
    pool_size = cap + 1 + $urandom_range(0, 6);
    for (i = 0; i < pool_size; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'sh80000000;
    key_pool[1] = 32'sh7FFFFFFF;
    key_pool[2] = 0;
    key_pool[3] = -1;
  endtask

  task automatic test_random_traffic();
    int caps [8];
    int p;
    int n;
    logic signed [KEY_W-1:0] key;
    caps = '{16, 1, $urandom_range(3, 15), 0, 16, 2, $urandom_range(3, 15), 16};
    for (p = 0; p < 8; p++) begin
      set_capacity(caps[p]);
      fill_key_pool(caps[p]);
      // one phase runs with no gaps on either side
      steady_flow = (p == 4);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        // mostly reuse a small key set so hits and evictions are common
        key = ($urandom_range(99) < 10) ? $urandom : key_pool[$urandom_range(pool_size - 1)];
        send_op(1'($urandom_range(1)), key, $urandom);
      end
    end
    steady_flow = 1'b0;
  endtask

  task automatic test_backpressure();
    int n;
    set_capacity(4);
    fill_key_pool(4);
    steady_flow  = 1'b1;
    hold_len     = 300;
    hold_req_cnt = hold_req_cnt + 1;
    for (n = 0; n < 24; n++)
      send_op(1'($urandom_range(1)), key_pool[$urandom_range(pool_size - 1)], $urandom);
    steady_flow = 1'b0;
  endtask

  initial begin
    shadow_capacity = 16;
    clear_shadow();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_ops();
    test_capacity_limits();
    test_random_traffic();
    test_backpressure();
    drain_replies();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/lkv_pkg.sv
rtl/lkv_store.sv
rtl/lkv_engine.sv
rtl/lru_key_value_cache.sv
verif/tb_top.sv
